// File: hdl/six_stage_lfo_phaser_core_defines.svh
// assertion macros for the phaser core
`ifndef SIX_STAGE_LFO_PHASER_CORE_DEFINES_SVH
`define SIX_STAGE_LFO_PHASER_CORE_DEFINES_SVH

// assert that a implies b on every clock edge out of reset
`define PH_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");

// assert that a implies b in the next cycle
`define PH_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: hdl/phsr_pkg.sv
`default_nettype none
package phsr_pkg;
    localparam int STAGES_DEF      = 6;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int PHASE_BITS_DEF  = 24;

    // register indexes
    localparam logic [2:0] REG_LFO_STEP   = 3'd0;
    localparam logic [2:0] REG_RANGE_LOW  = 3'd1;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd2;
    localparam logic [2:0] REG_FEEDBACK   = 3'd3;
    localparam logic [2:0] REG_DEPTH      = 3'd4;

    // quarter sine, Q1.16, 17 points
    function automatic logic [16:0] quarter_sine(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd6424;
            5'd2:  v = 17'd12785;
            5'd3:  v = 17'd19024;
            5'd4:  v = 17'd25079;
            5'd5:  v = 17'd30893;
            5'd6:  v = 17'd36410;
            5'd7:  v = 17'd41576;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd50660;
            5'd10: v = 17'd54491;
            5'd11: v = 17'd57798;
            5'd12: v = 17'd60547;
            5'd13: v = 17'd62714;
            5'd14: v = 17'd64277;
            5'd15: v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: hdl/phsr_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
// computes ((65536-d)<<16 + den/2) / den with den = 65536+d
module phsr_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [16:0] den,
    input  wire logic [32:0] num,
    output logic             busy,
    output logic [16:0]      quot
);
    logic [32:0] num_reg, num_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [17:0] trial;
    logic [17:0] shifted;

    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg[16:0], num_reg[32]};
        trial    = shifted - {1'b0, den};
        if (start) begin
            num_next = num;
            rem_next = '0;
            q_next   = '0;
            cnt_next = 6'd33;
        end else if (cnt_reg != 6'd0) begin
            num_next = {num_reg[31:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (!trial[17]) begin
                rem_next = trial;
                q_next   = {q_reg[15:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign quot = q_reg;
endmodule
`default_nettype wire

// File: hdl/six_stage_lfo_phaser_core.sv
// an accepted item steps through LFO, D1, D2, DIV, DIVW (waiting on the divider), FB,
//   SY and SM per stage, and WET, then m_tvalid rises in OUT; the pace is set by the
//   coefficient divider and the shared multiplier stepping the all-pass chain two products
//   per stage; s_tready stays low until the result is taken
// reset: synchronous active-low aresetn clears registers to defaults, phase,
//   feedback history and all-pass memories to zero
`default_nettype none
`include "six_stage_lfo_phaser_core_defines.svh"
module six_stage_lfo_phaser_core #(
    parameter int STAGES      = phsr_pkg::STAGES_DEF,
    parameter int SAMPLE_BITS = phsr_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = phsr_pkg::PHASE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,      // sample_out
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import phsr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int TW = ((SAMPLE_BITS+7)/8)*8;
    localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LFO  = 4'd1;
    localparam logic [3:0] ST_D1   = 4'd2;
    localparam logic [3:0] ST_D2   = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_DIVW = 4'd5;
    localparam logic [3:0] ST_FB   = 4'd6;
    localparam logic [3:0] ST_SY   = 4'd7;
    localparam logic [3:0] ST_SM   = 4'd8;
    localparam logic [3:0] ST_WET  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [23:0] lfo_step_reg;
    logic [15:0] range_low_reg, range_high_reg, feedback_reg, depth_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic signed [SB-1:0] last_reg;
    logic signed [31:0] mem_reg [STAGES];
    logic [3:0] state_reg;
    logic signed [SB-1:0] dry_reg, out_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [16:0] u_reg, d_reg, a_reg;
    logic [32:0] dprod_reg;
    logic [SW-1:0] stg_reg;
    logic out_valid_reg;

    // config port
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfo_step_reg   <= '0;
            range_low_reg  <= '0;
            range_high_reg <= 16'hFFFF;
            feedback_reg   <= '0;
            depth_reg      <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_LFO_STEP:   lfo_step_reg   <= pwdata[23:0];
                REG_RANGE_LOW:  range_low_reg  <= pwdata[15:0];
                REG_RANGE_HIGH: range_high_reg <= pwdata[15:0];
                REG_FEEDBACK:   feedback_reg   <= pwdata[15:0];
                REG_DEPTH:      depth_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[4:2])
            REG_LFO_STEP:   prdata = {8'd0, lfo_step_reg};
            REG_RANGE_LOW:  prdata = {16'd0, range_low_reg};
            REG_RANGE_HIGH: prdata = {16'd0, range_high_reg};
            REG_FEEDBACK:   prdata = {16'd0, feedback_reg};
            REG_DEPTH:      prdata = {16'd0, depth_reg};
            default:        prdata = '0;
        endcase
    end

    // lfo from quarter-wave table
    logic [31:0] p32;
    logic [1:0]  quad;
    logic [16:0] xq;
    logic [4:0]  tidx;
    logic [16:0] s0, s1, sval;
    logic [28:0] iprod;
    logic [16:0] u_calc;
    always_comb begin
        p32  = 32'({phase_reg, 32'd0} >> PHASE_BITS);
        quad = p32[31:30];
        xq   = {1'b0, p32[29:14]};
        if (quad[0]) xq = 17'h10000 - xq;
        tidx = xq[16:12];
        s0   = quarter_sine(tidx);
        s1   = quarter_sine(tidx + 5'd1);
        iprod = (s1 - s0) * {17'd0, xq[11:0]};
        sval = tidx[4] ? 17'h10000 : (s0 + iprod[28:12]);
        if (quad[1]) u_calc = (17'h10000 - sval) >> 1;
        else u_calc = 17'(({1'b0, 17'h10000} + {1'b0, sval}) >> 1);
    end

    // shared signed multiplier, 18 x 33 operand sets chosen per state
    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [50:0] mul_sh;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_D1:  begin
                mul_a = {2'd0, range_low_reg};
                mul_b = 33'sh10000 - {16'd0, u_reg};
            end
            ST_D2:  begin
                mul_a = {2'd0, range_high_reg};
                mul_b = {16'd0, u_reg};
            end
            ST_FB:  begin
                mul_a = {2'd0, feedback_reg};
                mul_b = 33'(last_reg);
            end
            ST_SY:  begin
                mul_a = {1'b0, a_reg};
                mul_b = 33'(x_reg);
            end
            ST_SM:  begin
                mul_a = {1'b0, a_reg};
                mul_b = 33'(y_reg);
            end
            ST_WET: begin
                mul_a = {2'd0, depth_reg};
                mul_b = 33'(last_reg);
            end
            default: ;
        endcase
        mul_p  = mul_a * mul_b;
        mul_sh = mul_p >>> 16;
    end

    // saturation helpers
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -68'sh80000000) return -32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic signed [SB-1:0] satsb(input logic signed [67:0] v);
        logic signed [67:0] hi, lo;
        hi = (68'sd1 <<< (SB-1)) - 68'sd1;
        lo = -hi - 68'sd1;
        if (v > hi) return hi[SB-1:0];
        if (v < lo) return lo[SB-1:0];
        return v[SB-1:0];
    endfunction

    // coefficient divider
    logic        div_start, div_busy;
    logic [16:0] div_q, den;
    logic [32:0] div_num;
    assign den       = 17'h10000 + d_reg;
    assign div_num   = {(17'h10000 - d_reg), 16'd0} + {17'd0, den[16:1]};
    assign div_start = (state_reg == ST_DIV);
    phsr_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .den(den), .num(div_num), .busy(div_busy), .quot(div_q)
    );

    logic [PHASE_BITS-1:0] step_al;
    always_comb begin
        if (PHASE_BITS >= 24) step_al = PHASE_BITS'({lfo_step_reg} << (PHASE_BITS-24));
        else step_al = PHASE_BITS'(lfo_step_reg >> (24-PHASE_BITS));
    end

    logic s_acc, m_acc;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            stg_reg       <= '0;
            for (int i = 0; i < STAGES; i++) mem_reg[i] <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_acc) begin
                    dry_reg   <= s_tdata[SB-1:0];
                    state_reg <= ST_LFO;
                end
                ST_LFO: begin
                    u_reg     <= u_calc;
                    phase_reg <= phase_reg + step_al;
                    state_reg <= ST_D1;
                end
                ST_D1: begin
                    dprod_reg <= mul_p[32:0];
                    state_reg <= ST_D2;
                end
                ST_D2: begin
                    d_reg     <= 17'((dprod_reg + mul_p[32:0]) >> 16);
                    state_reg <= ST_DIV;
                end
                ST_DIV: state_reg <= ST_DIVW;
                ST_DIVW: if (!div_busy) begin
                    a_reg     <= div_q;
                    state_reg <= ST_FB;
                end
                ST_FB: begin
                    x_reg     <= 32'(satsb(68'(dry_reg) + mul_sh));
                    stg_reg   <= SW'(STAGES-1);
                    state_reg <= ST_SY;
                end
                ST_SY: begin
                    y_reg     <= sat32(68'(mem_reg[stg_reg]) - mul_sh);
                    state_reg <= ST_SM;
                end
                ST_SM: begin
                    mem_reg[stg_reg] <= sat32(mul_sh + 68'(x_reg));
                    x_reg <= y_reg;
                    if (stg_reg == '0) begin
                        last_reg  <= satsb(68'(y_reg));
                        state_reg <= ST_WET;
                    end else begin
                        stg_reg   <= stg_reg - SW'(1);
                        state_reg <= ST_SY;
                    end
                end
                ST_WET: begin
                    out_reg       <= satsb(68'(dry_reg) + mul_sh);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT: if (m_acc) begin
                    out_valid_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TW'(unsigned'(out_reg));

    `PH_ASSERT_IMPL(a_valid_in_out, aclk, aresetn, m_tvalid, state_reg == ST_OUT)
    `PH_ASSERT_NEXT(a_acc_starts, aclk, aresetn, s_acc, state_reg == ST_LFO)
    `PH_ASSERT_IMPL(a_no_ready_busy, aclk, aresetn, s_tready, !m_tvalid)
endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // [23:0] sample_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [23:0] sample_out
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    six_stage_lfo_phaser_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor copy of registers and state
    logic [23:0] step_q;
    logic [15:0] lo_q, hi_q, fb_q, depth_q;
    logic [23:0] phase_q;
    longint      chain_hist;
    longint      allpass_mem [6];
    logic [16:0] sine_pts [17] = '{0, 6424, 12785, 19024, 25079, 30893, 36410, 41576,
        46341, 50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};

    logic [23:0] phased_q [$];
    int          errors = 0;
    bit          quiet_m = 1'b0;
    bit          quiet_s = 1'b0;
    int          idle_cnt = 0;

    function automatic longint clamp(longint v, int bits);
        longint top;
        top = (longint'(1) << (bits - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // arithmetic shift floors for negative values
    function automatic longint q16(longint v);
        return v >>> 16;
    endfunction

    function automatic logic [23:0] phase_sample(logic [23:0] din);
        longint dry, x, y, u, s, d, den, a, res;
        logic [31:0] p32;
        logic [1:0] quad;
        longint pos, idx, frac;
        dry = longint'($signed(din));
        p32 = {phase_q, 8'd0};
        quad = p32[31:30];
        pos = p32[29:14];
        if (quad[0]) pos = 65536 - pos;
        idx = pos >> 12;
        frac = pos & 4095;
        if (idx >= 16) s = sine_pts[16];
        else s = sine_pts[idx] + (((sine_pts[idx+1] - sine_pts[idx]) * frac) >> 12);
        u = (quad >= 2) ? (65536 - s) >> 1 : (65536 + s) >> 1;
        d = (longint'(lo_q) * (65536 - u) + longint'(hi_q) * u) >> 16;
        den = 65536 + d;
        a = (((65536 - d) << 16) + den / 2) / den;
        phase_q = phase_q + step_q;
        x = clamp(dry + q16(chain_hist * longint'(fb_q)), 24);
        for (int i = 5; i >= 0; i--) begin
            y = clamp(allpass_mem[i] - q16(a * x), 32);
            allpass_mem[i] = clamp(q16(a * y) + x, 32);
            x = y;
        end
        chain_hist = clamp(x, 24);
        res = clamp(dry + q16(chain_hist * longint'(depth_q)), 24);
        return res[23:0];
    endfunction

    // setup and access cycle; the caller ends the transfer
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_LFO_STEP:   step_q = val[23:0];
            REG_RANGE_LOW:  lo_q = val[15:0];
            REG_RANGE_HIGH: hi_q = val[15:0];
            REG_FEEDBACK:   fb_q = val[15:0];
            REG_DEPTH:      depth_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] st, lo, hi, fb, dp);
        reg_write(REG_LFO_STEP, st);
        reg_write(REG_RANGE_LOW, lo);
        reg_write(REG_RANGE_HIGH, hi);
        reg_write(REG_FEEDBACK, fb);
        reg_write(REG_DEPTH, dp);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // send one item; expectation queued at acceptance
    task automatic send_sample(logic [23:0] v);
        int gap;
        gap = 0;
        while (!quiet_s && $urandom_range(99) < 18) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        phased_q.push_back(phase_sample(v));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (phased_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(2000)) - 1000);
            default: return 24'($urandom());
        endcase
    endfunction

    // result side: random stall and compare
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (phased_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time,
                        m_tdata);
                    errors++;
                end else begin
                    if (m_tdata !== phased_q[0]) begin
                        $display("%0t: sample_out expected %h actual %h", $time,
                            phased_q[0], m_tdata);
                        errors++;
                    end
                    void'(phased_q.pop_front());
                end
            end
            m_tready <= quiet_m || ($urandom_range(99) >= 18);
        end
    end

    // watchdog on accepted items and register accesses
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    typedef struct {
        logic [23:0] din;
        bit          known;
        logic [23:0] dout;
    } stim_row_t;

    // directed rows at reset settings: depth zero gives the dry sample back
    stim_row_t dir_rows [] = '{
        '{24'h000000, 1, 24'h000000},
        '{24'h7FFFFF, 1, 24'h7FFFFF},
        '{24'h800000, 1, 24'h800000},
        '{24'h000001, 1, 24'h000001},
        '{24'hFFFFFF, 1, 24'hFFFFFF},
        '{24'h555555, 1, 24'h555555},
        '{24'hAAAAAA, 1, 24'hAAAAAA}
    };

    initial begin
        step_q = 0; lo_q = 0; hi_q = 16'hFFFF; fb_q = 0; depth_q = 0;
        phase_q = 0; chain_hist = 0;
        foreach (allpass_mem[i]) allpass_mem[i] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].din);
            if (dir_rows[i].known && phased_q[$] !== dir_rows[i].dout) begin
                $display("%0t: model row %0d expected %h actual %h", $time, i,
                    dir_rows[i].dout, phased_q[$]);
                errors++;
            end
        end
        wait_drained();

        // full feedback and depth, fast sweep, extremes and overflow drive
        set_all(32'hFFFFFF, 0, 32'hFFFF, 32'hFFFF, 32'hFFFF);
        for (int i = 0; i < 16; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000);
        wait_drained();
        // reversed range, zero step with stray upper bits masked
        set_all(32'hFF000000, 32'hFFFF, 32'h0100, 32'h8000, 32'h4000);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());
        wait_drained();

        // random phases with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            set_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            if (ph == 3) set_all(0, 0, 0, 0, 0);
            if (ph == 4) set_all(32'hFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
            quiet_s = (ph == 5);
            quiet_m = (ph == 5);
            for (int i = 0; i < 150; i++) begin
                send_sample(rand_sample());
                if (i == 75) begin
                    s_tvalid <= 1'b0;
                    while (phased_q.size() != 0) @(posedge aclk);
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
